### hdl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Types, colors and the label font for the test-pattern pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned ColorW = 16;

  localparam logic [ColorW-1:0] ColorBlack = 16'h0000;
  localparam logic [ColorW-1:0] ColorRed   = 16'hF800;
  localparam logic [ColorW-1:0] ColorGreen = 16'h07E0;
  localparam logic [ColorW-1:0] ColorBlue  = 16'h001F;
  localparam logic [ColorW-1:0] ColorWhite = 16'hFFFF;

  localparam int unsigned LabelX0    = 126;
  localparam int unsigned LabelY0    = 41;
  localparam int unsigned LabelRows  = 7;
  localparam int unsigned LabelCols  = 5;
  localparam int unsigned LabelPitch = 6;
  localparam int unsigned LabelLen   = 18;
  localparam int unsigned LabelSpan  = LabelLen * LabelPitch;

  localparam int unsigned BandRedRow   = 90;
  localparam int unsigned BandGreenRow = 180;
  localparam int unsigned BandBlueRow  = 270;

  localparam int unsigned RelW  = $clog2(LabelSpan);
  localparam int unsigned CellW = $clog2(LabelLen);
  localparam int unsigned ColW  = $clog2(LabelPitch);
  localparam int unsigned RowW  = $clog2(LabelRows);

  // floor(rel / 6) as (rel * 43) >> 8, exact for rel below the label span
  localparam int unsigned DivMul   = 43;
  localparam int unsigned DivShift = 8;
  localparam int unsigned ProdW    = RelW + 6;

  typedef enum logic [1:0] {
    BAND_BLACK,
    BAND_RED,
    BAND_GREEN,
    BAND_BLUE
  } band_e;

  // position of a pixel inside the label grid
  typedef struct packed {
    logic             hit_ok;
    logic [CellW-1:0] char_idx;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
  } label_pos_t;

  // glyph rows, row 0 in the top bits of each entry; bit 4 of a row is leftmost
  localparam logic [LabelRows*LabelCols-1:0] Glyphs [LabelLen] = '{
    35'h7E10F421F,  // 1F 10 10 1E 10 10 1F
    35'h3E107043E,  // 0F 10 10 0E 01 01 1E
    35'h7A31F4210,  // 1E 11 11 1E 10 10 10
    35'h0000F8000,  // 00 00 00 1F 00 00 00
    35'h46318C544,  // 11 11 11 11 11 0A 04
    35'h000E8C62E,  // 00 00 0E 11 11 11 0E
    35'h3A308422E,  // 0E 11 10 10 10 11 0E
    35'h000E0BE2F,  // 00 00 0E 01 0F 11 0F
    35'h109F210A2,  // 04 04 1F 04 04 05 02
    35'h000000000,
    35'h42108421F,  // 10 10 10 10 10 10 1F
    35'h3A308422E,  // 0E 11 10 10 10 11 0E
    35'h7A318C63E,  // 1E 11 11 11 11 11 1E
    35'h000000000,
    35'h7C8421084,  // 1F 04 04 04 04 04 04
    35'h7E10F421F,  // 1F 10 10 1E 10 10 1F
    35'h3E107043E,  // 0F 10 10 0E 01 01 1E
    35'h7C8421084   // 1F 04 04 04 04 04 04
  };

  function automatic logic [LabelCols-1:0] glyph_row(logic [CellW-1:0] char_idx,
                                                     logic [RowW-1:0]  row);
    logic [LabelRows*LabelCols-1:0] bits;
    logic [LabelCols-1:0]           res;
    res = '0;
    if (char_idx < CellW'(LabelLen) && row < RowW'(LabelRows)) begin
      bits = Glyphs[char_idx];
      res  = bits[(LabelRows - 1 - row) * LabelCols +: LabelCols];
    end
    return res;
  endfunction

  function automatic logic [ColorW-1:0] band_color(band_e band);
    logic [ColorW-1:0] c;
    case (band)
      BAND_BLACK: c = ColorBlack;
      BAND_RED:   c = ColorRed;
      BAND_GREEN: c = ColorGreen;
      BAND_BLUE:  c = ColorBlue;
      default:    c = ColorBlack;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/dtp_if.sv
// ----------------------------------------------------------------------------
// dtp channel interfaces
// Valid/ready channels for pixel coordinates and pixel colors.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtp_coord_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface dtp_color_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

### hdl/dtp_label_lookup.sv
// ----------------------------------------------------------------------------
// dtp_label_lookup
// Font lookup: tells whether a label grid position is a lit glyph pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_label_lookup import dtp_pkg::*; (
  input  label_pos_t pos_i,
  output logic       lit_o
);

  logic [LabelCols-1:0] row_bits;

  assign row_bits = glyph_row(pos_i.char_idx, pos_i.row);

  // sixth column of each cell is the gap between characters
  always_comb begin
    lit_o = 1'b0;
    if (pos_i.hit_ok && pos_i.col < ColW'(LabelCols)) begin
      lit_o = row_bits[ColW'(LabelCols - 1) - pos_i.col];
    end
  end

endmodule

`default_nettype wire

### hdl/display_test_pattern_pixel.sv
// ----------------------------------------------------------------------------
// display_test_pattern_pixel
// RGB565 test-pattern color for one pixel: white frame, white text label,
// four horizontal color bands.
// ----------------------------------------------------------------------------
//  port      dir  handshake      payload
//  coord_i   in   valid/ready    pixel_x[9:0], pixel_y[9:0]
//  color_o   out  valid/ready    pixel_color[15:0]
//
//  three register stages: window/band decode, cell/column split, color
//  one request enters and one leaves every cycle while the output is not
//  stalled; a stage moves on when it is empty or the stage after it moves
//  on, so a stalled output holds the pipeline in place with nothing dropped
//  reset clears only the stage valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module display_test_pattern_pixel import dtp_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 360,
  parameter int unsigned SCREEN_HEIGHT = 360
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  dtp_coord_if.sink     coord_i,
  dtp_color_if.source   color_o
);

  localparam logic [CoordW-1:0] LastX = CoordW'(SCREEN_WIDTH - 1);
  localparam logic [CoordW-1:0] LastY = CoordW'(SCREEN_HEIGHT - 1);

  logic adv_a, adv_b, adv_c;
  logic va_q, vb_q, vc_q;

  // stage a
  logic             a_frame_q, a_win_q;
  logic [RelW-1:0]  a_rel_q;
  logic [RowW-1:0]  a_row_q;
  band_e            a_band_q;
  logic             a_frame_d, a_win_d;
  logic [CoordW-1:0] x_off;
  band_e            a_band_d;

  // stage b
  logic             b_frame_q;
  band_e            b_band_q;
  label_pos_t       b_pos_q, b_pos_d;
  logic [ProdW-1:0] b_prod;
  logic [ColW+CellW-1:0] b_cell6;

  // stage c
  logic [ColorW-1:0] color_q, color_d;
  logic              lit;

  assign adv_c = !vc_q || color_o.ready;
  assign adv_b = !vb_q || adv_c;
  assign adv_a = !va_q || adv_b;
  assign coord_i.ready = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= coord_i.valid;
      if (adv_b) vb_q <= va_q;
      if (adv_c) vc_q <= vb_q;
    end
  end

  // stage a: frame, label window and band
  assign x_off = coord_i.pixel_x - CoordW'(LabelX0);

  always_comb begin
    a_frame_d = coord_i.pixel_x == '0 || coord_i.pixel_y == '0 ||
                coord_i.pixel_x == LastX || coord_i.pixel_y == LastY;
    a_win_d   = coord_i.pixel_x >= CoordW'(LabelX0) &&
                coord_i.pixel_x <  CoordW'(LabelX0 + LabelSpan) &&
                coord_i.pixel_y >= CoordW'(LabelY0) &&
                coord_i.pixel_y <  CoordW'(LabelY0 + LabelRows);
    if (coord_i.pixel_y < CoordW'(BandRedRow)) begin
      a_band_d = BAND_BLACK;
    end else if (coord_i.pixel_y < CoordW'(BandGreenRow)) begin
      a_band_d = BAND_RED;
    end else if (coord_i.pixel_y < CoordW'(BandBlueRow)) begin
      a_band_d = BAND_GREEN;
    end else begin
      a_band_d = BAND_BLUE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && coord_i.valid) begin
      a_frame_q <= a_frame_d;
      a_win_q   <= a_win_d;
      a_rel_q   <= x_off[RelW-1:0];
      a_row_q   <= RowW'(coord_i.pixel_y - CoordW'(LabelY0));
      a_band_q  <= a_band_d;
    end
  end

  // stage b: split offset into character cell and column
  assign b_prod  = ProdW'(a_rel_q) * ProdW'(DivMul);
  assign b_cell6 = (ColW + CellW)'(b_prod[DivShift +: CellW]) * (ColW + CellW)'(LabelPitch);

  always_comb begin
    b_pos_d.hit_ok   = a_win_q;
    b_pos_d.char_idx = b_prod[DivShift +: CellW];
    b_pos_d.col      = ColW'((ColW + CellW)'(a_rel_q) - b_cell6);
    b_pos_d.row      = a_row_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_b && va_q) begin
      b_frame_q <= a_frame_q;
      b_band_q  <= a_band_q;
      b_pos_q   <= b_pos_d;
    end
  end

  // stage c: font lookup and color select
  dtp_label_lookup u_lookup (
    .pos_i (b_pos_q),
    .lit_o (lit)
  );

  assign color_d = (b_frame_q || lit) ? ColorWhite : band_color(b_band_q);

  always_ff @(posedge clk_i) begin
    if (adv_c && vb_q) begin
      color_q <= color_d;
    end
  end

  assign color_o.valid       = vc_q;
  assign color_o.pixel_color = color_q;

  // assertions
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !adv_c |=> vb_q && $stable(b_pos_q) && $stable(b_band_q))
    else $error("stage b changed while stalled");

  a_frame_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && adv_c && b_frame_q |=> vc_q && color_q == ColorWhite)
    else $error("frame pixel not white");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && b_pos_q.hit_ok |-> b_pos_q.col < ColW'(LabelPitch) &&
                               b_pos_q.char_idx < CellW'(LabelLen))
    else $error("label cell split out of range");

endmodule

`default_nettype wire
